// ----- src/pp_pkg.sv -----
// Package for the polygon perimeter block: widths, limits and the sequencer state type.
// Used by pp_sqrt and polygon_perimeter; depends on nothing else.
`default_nettype none

package pp_pkg;

    localparam int COORD_W      = 24;
    localparam int DIFF_W       = COORD_W + 1;
    localparam int SQ_W         = 2 * DIFF_W;
    localparam int ROOT_W       = DIFF_W;
    localparam int REM_W        = ROOT_W + 2;
    localparam int ITER_W       = $clog2(ROOT_W);
    localparam int SUM_W        = 40;
    localparam int MAX_VERTICES = 1024;
    localparam int CNT_W        = 11;
    localparam int IN_DATA_W    = 48;
    localparam int OUT_DATA_W   = 56;

    localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_VERTICES);

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_DX    = 7'b0000010,
        ST_DY    = 7'b0000100,
        ST_SQ    = 7'b0001000,
        ST_START = 7'b0010000,
        ST_ROOT  = 7'b0100000,
        ST_ACC   = 7'b1000000
    } pp_state_t;

    typedef enum logic [1:0] {
        RES_EMPTY = 2'b01,
        RES_FULL  = 2'b10
    } pp_res_t;

endpackage

`default_nettype wire

// ----- src/pp_sqrt.sv -----
// Restoring integer square root, one result bit per clock.
// Depends on pp_pkg for the radicand and root widths.
`default_nettype none

module pp_sqrt (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          start,
    input  wire logic [pp_pkg::SQ_W-1:0]       radicand,
    output logic                               done,
    output logic [pp_pkg::ROOT_W-1:0]          root
);

    logic                          busy_reg, busy_next;
    logic                          done_reg, done_next;
    logic [pp_pkg::ITER_W-1:0]     iter_reg, iter_next;
    logic [pp_pkg::SQ_W-1:0]       rad_reg, rad_next;
    logic [pp_pkg::REM_W-1:0]      rem_reg, rem_next;
    logic [pp_pkg::ROOT_W-1:0]     root_reg, root_next;

    logic [pp_pkg::REM_W+1:0]      rem_sh;
    logic [pp_pkg::REM_W+1:0]      trial;
    logic [pp_pkg::REM_W+1:0]      diff;

    // Bring down the next two radicand bits and try appending a one to the root.
    assign rem_sh = {rem_reg, rad_reg[pp_pkg::SQ_W-1 -: 2]};
    assign trial  = {2'b00, root_reg, 2'b01};
    assign diff   = rem_sh - trial;

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        iter_next = iter_reg;
        rad_next  = rad_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        if (start) begin
            busy_next = 1'b1;
            iter_next = '0;
            rad_next  = radicand;
            rem_next  = '0;
            root_next = '0;
        end else if (busy_reg) begin
            rad_next = {rad_reg[pp_pkg::SQ_W-3:0], 2'b00};
            if (rem_sh >= trial) begin
                rem_next  = diff[pp_pkg::REM_W-1:0];
                root_next = {root_reg[pp_pkg::ROOT_W-2:0], 1'b1};
            end else begin
                rem_next  = rem_sh[pp_pkg::REM_W-1:0];
                root_next = {root_reg[pp_pkg::ROOT_W-2:0], 1'b0};
            end
            iter_next = iter_reg + 1'b1;
            if (iter_reg == pp_pkg::ITER_W'(pp_pkg::ROOT_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            iter_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            iter_reg <= iter_next;
        end
        rad_reg  <= rad_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

`default_nettype wire

// ----- src/polygon_perimeter.sv -----
// A vertex that follows another without closing the polygon holds s_tready low while the
// sequencer runs ST_DX, ST_DY, ST_SQ (square dx and dy), ST_START (start the root), ST_ROOT
// (25 root bits) and ST_ACC (add the edge); a first vertex not flagged last leaves it idle.
// A vertex flagged last runs two such edges (one if it is also the first vertex) and loads its
// result once the result register is free. Throughput: one vertex at a time. Reset: synchronous,
// active-low aresetn clears control, sum, count and result state, not the datapath registers.
`default_nettype none

module polygon_perimeter (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // [23:0] vertex_x, [47:24] vertex_y
    input  wire logic [pp_pkg::IN_DATA_W-1:0]      s_tdata,
    input  wire logic                              s_tlast,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // [39:0] perimeter, [50:40] vertex_count, [55:51] zero
    output logic [pp_pkg::OUT_DATA_W-1:0]          m_tdata,
    // [0] saturated
    output logic                                   m_tuser
);

    localparam int CW = pp_pkg::COORD_W;

    pp_pkg::pp_state_t               state_reg, state_next;
    logic                            closing_reg, closing_next;
    logic                            last_reg, last_next;
    logic signed [CW-1:0]            first_x_reg, first_x_next, first_y_reg, first_y_next;
    logic signed [CW-1:0]            prev_x_reg, prev_x_next, prev_y_reg, prev_y_next;
    logic signed [CW-1:0]            cur_x_reg, cur_x_next, cur_y_reg, cur_y_next;
    logic [pp_pkg::SUM_W-1:0]        sum_reg, sum_next;
    logic [pp_pkg::CNT_W-1:0]        count_reg, count_next;
    logic                            sat_reg, sat_next;
    logic [pp_pkg::DIFF_W-1:0]       mag_reg, mag_next;
    logic [pp_pkg::SQ_W-1:0]         prod_reg, prod_next;
    logic [pp_pkg::SQ_W-1:0]         rad_reg, rad_next;

    // Result holding register: the sequencer may start a new polygon while it waits.
    pp_pkg::pp_res_t                 res_reg, res_next;
    logic [pp_pkg::SUM_W-1:0]        out_perim_reg, out_perim_next;
    logic [pp_pkg::CNT_W-1:0]        out_cnt_reg, out_cnt_next;
    logic                            out_sat_reg, out_sat_next;

    logic                            sqrt_start;
    logic                            sqrt_done;
    logic [pp_pkg::ROOT_W-1:0]       sqrt_root;
    logic [pp_pkg::SQ_W-1:0]         radicand;

    logic signed [CW-1:0]            in_x, in_y;
    logic signed [CW-1:0]            a_x, a_y, b_x, b_y;
    logic signed [pp_pkg::DIFF_W-1:0] d_x, d_y;
    logic [pp_pkg::DIFF_W-1:0]       abs_x, abs_y;
    logic [pp_pkg::SQ_W-1:0]         square;
    logic [pp_pkg::SUM_W:0]          sum_wide;
    logic                            res_take;

    assign in_x = s_tdata[CW-1:0];
    assign in_y = s_tdata[2*CW-1:CW];

    // The normal edge runs from the previous vertex to the new one; the closing edge runs
    // from the new vertex back to the first one.
    assign a_x = closing_reg ? cur_x_reg   : prev_x_reg;
    assign a_y = closing_reg ? cur_y_reg   : prev_y_reg;
    assign b_x = closing_reg ? first_x_reg : cur_x_reg;
    assign b_y = closing_reg ? first_y_reg : cur_y_reg;

    assign d_x   = {a_x[CW-1], a_x} - {b_x[CW-1], b_x};
    assign d_y   = {a_y[CW-1], a_y} - {b_y[CW-1], b_y};
    assign abs_x = d_x[pp_pkg::DIFF_W-1] ? (~d_x + 1'b1) : d_x;
    assign abs_y = d_y[pp_pkg::DIFF_W-1] ? (~d_y + 1'b1) : d_y;

    // The one multiplier squares dx and then dy from the magnitude register.
    assign square = {{pp_pkg::DIFF_W{1'b0}}, mag_reg} * {{pp_pkg::DIFF_W{1'b0}}, mag_reg};

    assign radicand = rad_reg + prod_reg;
    assign sum_wide = {1'b0, sum_reg} + {{(pp_pkg::SUM_W + 1 - pp_pkg::ROOT_W){1'b0}}, sqrt_root};

    assign s_tready = (state_reg == pp_pkg::ST_IDLE);
    assign res_take = (res_reg == pp_pkg::RES_FULL) && m_tready;

    pp_sqrt u_sqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (sqrt_start),
        .radicand (radicand),
        .done     (sqrt_done),
        .root     (sqrt_root)
    );

    always_comb begin
        state_next     = state_reg;
        closing_next   = closing_reg;
        last_next      = last_reg;
        first_x_next   = first_x_reg;
        first_y_next   = first_y_reg;
        prev_x_next    = prev_x_reg;
        prev_y_next    = prev_y_reg;
        cur_x_next     = cur_x_reg;
        cur_y_next     = cur_y_reg;
        sum_next       = sum_reg;
        count_next     = count_reg;
        sat_next       = sat_reg;
        mag_next       = mag_reg;
        prod_next      = prod_reg;
        rad_next       = rad_reg;
        res_next       = res_take ? pp_pkg::RES_EMPTY : res_reg;
        out_perim_next = out_perim_reg;
        out_cnt_next   = out_cnt_reg;
        out_sat_next   = out_sat_reg;
        sqrt_start     = 1'b0;

        case (state_reg)
            pp_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    cur_x_next = in_x;
                    cur_y_next = in_y;
                    last_next  = s_tlast;
                    if (count_reg == '0) begin
                        // First vertex: no edge yet, unless it also closes the polygon.
                        first_x_next = in_x;
                        first_y_next = in_y;
                        prev_x_next  = in_x;
                        prev_y_next  = in_y;
                        count_next   = pp_pkg::CNT_W'(1);
                        closing_next = 1'b1;
                        if (s_tlast) begin
                            state_next = pp_pkg::ST_DX;
                        end
                    end else begin
                        if (count_reg < pp_pkg::CNT_MAX) begin
                            count_next = count_reg + 1'b1;
                        end
                        closing_next = 1'b0;
                        state_next   = pp_pkg::ST_DX;
                    end
                end
            end
            pp_pkg::ST_DX: begin
                mag_next   = abs_x;
                state_next = pp_pkg::ST_DY;
            end
            pp_pkg::ST_DY: begin
                prod_next  = square;
                mag_next   = abs_y;
                state_next = pp_pkg::ST_SQ;
            end
            pp_pkg::ST_SQ: begin
                rad_next   = prod_reg;
                prod_next  = square;
                state_next = pp_pkg::ST_START;
            end
            pp_pkg::ST_START: begin
                sqrt_start = 1'b1;
                state_next = pp_pkg::ST_ROOT;
            end
            pp_pkg::ST_ROOT: begin
                if (sqrt_done) begin
                    state_next = pp_pkg::ST_ACC;
                end
            end
            pp_pkg::ST_ACC: begin
                if (!closing_reg) begin
                    // Normal edge done: add it, then run the closing edge or wait for more.
                    if (sum_wide[pp_pkg::SUM_W]) begin
                        sum_next = pp_pkg::SUM_MAX;
                        sat_next = 1'b1;
                    end else begin
                        sum_next = sum_wide[pp_pkg::SUM_W-1:0];
                    end
                    prev_x_next = cur_x_reg;
                    prev_y_next = cur_y_reg;
                    if (last_reg) begin
                        closing_next = 1'b1;
                        state_next   = pp_pkg::ST_DX;
                    end else begin
                        state_next = pp_pkg::ST_IDLE;
                    end
                end else if (res_next == pp_pkg::RES_EMPTY) begin
                    // Closing edge done and the result register is free: hand out the result
                    // item and clear the polygon state.
                    if (sum_wide[pp_pkg::SUM_W]) begin
                        out_perim_next = pp_pkg::SUM_MAX;
                        out_sat_next   = 1'b1;
                    end else begin
                        out_perim_next = sum_wide[pp_pkg::SUM_W-1:0];
                        out_sat_next   = sat_reg;
                    end
                    out_cnt_next = count_reg;
                    res_next     = pp_pkg::RES_FULL;
                    sum_next     = '0;
                    count_next   = '0;
                    sat_next     = 1'b0;
                    first_x_next = '0;
                    first_y_next = '0;
                    prev_x_next  = '0;
                    prev_y_next  = '0;
                    closing_next = 1'b0;
                    state_next   = pp_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = pp_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= pp_pkg::ST_IDLE;
            closing_reg <= 1'b0;
            last_reg    <= 1'b0;
            first_x_reg <= '0;
            first_y_reg <= '0;
            prev_x_reg  <= '0;
            prev_y_reg  <= '0;
            sum_reg     <= '0;
            count_reg   <= '0;
            sat_reg     <= 1'b0;
            res_reg     <= pp_pkg::RES_EMPTY;
        end else begin
            state_reg   <= state_next;
            closing_reg <= closing_next;
            last_reg    <= last_next;
            first_x_reg <= first_x_next;
            first_y_reg <= first_y_next;
            prev_x_reg  <= prev_x_next;
            prev_y_reg  <= prev_y_next;
            sum_reg     <= sum_next;
            count_reg   <= count_next;
            sat_reg     <= sat_next;
            res_reg     <= res_next;
        end
        cur_x_reg     <= cur_x_next;
        cur_y_reg     <= cur_y_next;
        mag_reg       <= mag_next;
        prod_reg      <= prod_next;
        rad_reg       <= rad_next;
        out_perim_reg <= out_perim_next;
        out_cnt_reg   <= out_cnt_next;
        out_sat_reg   <= out_sat_next;
    end

    assign m_tvalid = (res_reg == pp_pkg::RES_FULL);
    assign m_tdata  = {{(pp_pkg::OUT_DATA_W - pp_pkg::SUM_W - pp_pkg::CNT_W){1'b0}},
                       out_cnt_reg, out_perim_reg};
    assign m_tuser  = out_sat_reg;

`ifndef SYNTHESIS
    // Once the sum has been clamped it stays pinned at its maximum until the polygon closes.
    assert property (@(posedge aclk) disable iff (!aresetn)
        sat_reg |-> (sum_reg == pp_pkg::SUM_MAX))
        else $error("saturation flag set while sum is below its maximum");

    // No edge length can be added before the first vertex of a polygon is stored.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg == '0) |-> (sum_reg == '0))
        else $error("running sum is nonzero with no vertex taken");

    // The vertex count never passes its ceiling.
    assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= pp_pkg::CNT_MAX)
        else $error("vertex count beyond its limit");

    // The root unit only reports completion while the sequencer is waiting on it.
    assert property (@(posedge aclk) disable iff (!aresetn)
        sqrt_done |-> (state_reg == pp_pkg::ST_ROOT))
        else $error("square root finished outside the wait state");
`endif

endmodule

`default_nettype wire
